// ===== sv/psw_pkg.sv =====
// ============================================================================
// Pump speed window monitor package
// Shared types, register indexes and constant-divide helpers.
// ============================================================================
`default_nettype none

package psw_pkg;

    // Field widths.
    localparam int FLOW_W  = 14;
    localparam int COUNT_W = 16;
    localparam int TICKS_W = 16;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOOD_PERSIST = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UF_PERSIST    = 1'd1;

    // Reset values.
    localparam logic [TICKS_W-1:0] BLOOD_PERSIST_RESET = 16'd10000;
    localparam logic [TICKS_W-1:0] UF_PERSIST_RESET    = 16'd15000;
    localparam logic [TICKS_W-1:0] COUNTDOWN_RESET     = 16'd10000;

    // Item kinds carried in the action field.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    // Widths of the window terms.
    localparam int MUL17_W = 19;  // flow * 17, flow up to 16383
    localparam int BEXP_W  = 15;  // blood expected count, up to 27851
    localparam int BTOL_W  = 12;  // blood tolerance, up to 2785
    localparam int UEXP_W  = 17;  // uf expected count, up to 69627
    localparam int UTOL_W  = 13;  // uf tolerance, up to 6962

    // Reciprocal constants: floor(x/d) = (x * M) >> S over the used input range.
    localparam logic [18:0] DIV10_MUL   = 19'd419431;
    localparam int          DIV10_SHIFT = 22;
    localparam logic [19:0] DIV100_MUL  = 20'd671089;
    localparam int          DIV100_SHIFT = 26;
    localparam logic [15:0] DIV5_MUL    = 16'd52429;
    localparam int          DIV5_SHIFT  = 18;

    // One input word.
    typedef struct packed {
        logic               action;
        logic [FLOW_W-1:0]  blood_flow_set;
        logic               high_flow;
        logic [FLOW_W-1:0]  uf_flow_set;
        logic [COUNT_W-1:0] blood_count;
        logic [COUNT_W-1:0] uf_count;
    } psw_item_t;

    // Expected counts and tolerances handed to the countdown stage.
    typedef struct packed {
        logic               action;
        logic [BEXP_W-1:0]  blood_expect;
        logic [BTOL_W-1:0]  blood_tol;
        logic [UEXP_W-1:0]  uf_expect;
        logic [UTOL_W-1:0]  uf_tol;
        logic [COUNT_W-1:0] blood_count;
        logic [COUNT_W-1:0] uf_count;
    } psw_window_t;

    // Divide by ten for values below 2^19.
    function automatic logic [BEXP_W-1:0] div10(input logic [MUL17_W-1:0] x);
        logic [37:0] prod;
        prod = 38'(x) * 38'(DIV10_MUL);
        return BEXP_W'(prod >> DIV10_SHIFT);
    endfunction

    // Divide by one hundred for values below 2^19.
    function automatic logic [BTOL_W-1:0] div100(input logic [MUL17_W-1:0] x);
        logic [38:0] prod;
        prod = 39'(x) * 39'(DIV100_MUL);
        return BTOL_W'(prod >> DIV100_SHIFT);
    endfunction

    // Divide by five for 16-bit values.
    function automatic logic [UTOL_W-1:0] div5(input logic [15:0] x);
        logic [31:0] prod;
        prod = 32'(x) * 32'(DIV5_MUL);
        return UTOL_W'(prod >> DIV5_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ===== sv/psw_if.sv =====
// ============================================================================
// Pump speed window monitor channels
// Valid/ready channels for the input words and the alarm words.
// ============================================================================
`default_nettype none

interface psw_item_if;
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [13:0]            blood_flow_set;
    logic                   high_flow;
    logic [13:0]            uf_flow_set;
    logic [15:0]            blood_count;
    logic [15:0]            uf_count;

    modport source (
        output valid, action, blood_flow_set, high_flow, uf_flow_set,
               blood_count, uf_count,
        input  ready
    );
    modport sink (
        input  valid, action, blood_flow_set, high_flow, uf_flow_set,
               blood_count, uf_count,
        output ready
    );
endinterface

interface psw_alarm_if;
    logic valid;
    logic ready;
    logic blood_alarm;
    logic uf_alarm;

    modport source (
        output valid, blood_alarm, uf_alarm,
        input  ready
    );
    modport sink (
        input  valid, blood_alarm, uf_alarm,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/pump_speed_window_monitor.sv =====
// ============================================================================
// Pump speed window monitor
// Checks blood and ultrafiltration pump speeds against setpoint windows.
// ============================================================================
// The block takes one word per clock cycle while input ready is high, and
// returns the alarm word of a speed check through the input, window and
// result registers; a tick word decrements the countdowns and returns
// nothing. The input register feeds the constant multipliers that form the
// windows, and the window register feeds the compare and countdown logic
// ahead of the result register. Input ready drops only while a finished
// alarm word waits at the result port and a check sits behind it.
`default_nettype none

module pump_speed_window_monitor
    import psw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    psw_item_if.sink                    item,
    psw_alarm_if.source                 alarm,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    psw_window_t win;
    logic        win_valid;
    logic        win_ready;

    // Window computation.
    psw_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .win       (win),
        .win_valid (win_valid),
        .win_ready (win_ready)
    );

    // Countdowns and result.
    psw_persist u_persist (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .alarm     (alarm)
    );

endmodule

`default_nettype wire

// ===== sv/psw_window.sv =====
// ============================================================================
// Speed window stage
// Registers the input word and forms the expected counts and tolerances.
// ============================================================================
`default_nettype none

module psw_window
    import psw_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    psw_item_if.sink    item,
    output psw_window_t win,
    output logic        win_valid,
    input  wire logic   win_ready
);

    logic        in_valid_reg;
    psw_item_t   in_reg;
    logic        win_valid_reg;
    psw_window_t win_reg;
    psw_window_t win_next;
    logic        win_load;

    logic [MUL17_W-1:0] blood_x17;
    logic [MUL17_W-1:0] uf_x17;
    logic [MUL17_W-1:0] div10_in;
    logic [BEXP_W-1:0]  quot10;
    logic [BTOL_W-1:0]  quot100;
    logic [BEXP_W-1:0]  blood_expect;
    logic [BTOL_W-1:0]  blood_tol_raw;

    // The window register takes a new word when empty or when drained.
    assign win_load   = !win_valid_reg || win_ready;
    assign item.ready = !in_valid_reg || win_load;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_reg.action         <= item.action;
            in_reg.blood_flow_set <= item.blood_flow_set;
            in_reg.high_flow      <= item.high_flow;
            in_reg.uf_flow_set    <= item.uf_flow_set;
            in_reg.blood_count    <= item.blood_count;
            in_reg.uf_count       <= item.uf_count;
        end
    end

    // Expected counts and tolerances by constant multiplies.
    // The tolerance of a floored quotient is taken straight from the setpoint,
    // so floor(floor(17f/10)/10) is floor(17f/100).
    always_comb
    begin
        blood_x17 = (MUL17_W'(in_reg.blood_flow_set) << 4)
                  + MUL17_W'(in_reg.blood_flow_set);
        uf_x17    = (MUL17_W'(in_reg.uf_flow_set) << 4)
                  + MUL17_W'(in_reg.uf_flow_set);

        div10_in = in_reg.high_flow ? MUL17_W'(in_reg.blood_flow_set) : blood_x17;
        quot10   = div10(div10_in);
        quot100  = div100(blood_x17);

        blood_expect  = in_reg.high_flow ? BEXP_W'(in_reg.blood_flow_set) : quot10;
        blood_tol_raw = in_reg.high_flow ? BTOL_W'(quot10) : quot100;

        win_next.action       = in_reg.action;
        win_next.blood_expect = blood_expect;
        // Small expected counts get a window of the whole count.
        win_next.blood_tol    = (blood_expect > BEXP_W'(10)) ? blood_tol_raw
                                                             : BTOL_W'(blood_expect);
        win_next.uf_expect    = UEXP_W'(uf_x17 >> 2);
        win_next.uf_tol       = div5(16'(uf_x17 >> 3));
        win_next.blood_count  = in_reg.blood_count;
        win_next.uf_count     = in_reg.uf_count;
    end

    // Window register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
        end
        else if (win_load)
        begin
            win_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_load)
        begin
            win_reg <= win_next;
        end
    end

    assign win       = win_reg;
    assign win_valid = win_valid_reg;

endmodule

`default_nettype wire

// ===== sv/psw_persist.sv =====
// ============================================================================
// Persistence countdown stage
// Compares counts with the windows, runs the four countdowns, holds the
// reload registers and the result register.
// ============================================================================
`default_nettype none

module psw_persist
    import psw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire psw_window_t            win,
    input  wire logic                   win_valid,
    output logic                        win_ready,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    psw_alarm_if.source                 alarm
);

    logic [TICKS_W-1:0] blood_persist_reg;
    logic [TICKS_W-1:0] uf_persist_reg;

    logic [TICKS_W-1:0] blood_over_reg,  blood_over_next;
    logic [TICKS_W-1:0] blood_under_reg, blood_under_next;
    logic [TICKS_W-1:0] uf_over_reg,     uf_over_next;
    logic [TICKS_W-1:0] uf_under_reg,    uf_under_next;

    logic alarm_valid_reg;
    logic blood_alarm_reg, blood_alarm_next;
    logic uf_alarm_reg,    uf_alarm_next;

    logic               out_free;
    logic               fire;
    logic               is_check;
    logic [COUNT_W-1:0] blood_hi, blood_lo;
    logic [UEXP_W-1:0]  uf_hi, uf_lo;
    logic               blood_above, blood_below;
    logic               uf_above, uf_below;

    function automatic logic [TICKS_W-1:0] dec_nonzero(input logic [TICKS_W-1:0] v);
        return (v != '0) ? v - TICKS_W'(1) : '0;
    endfunction

    // A tick leaves no word, so it drains even while the result waits.
    assign is_check  = (win.action == ACT_CHECK);
    assign out_free  = !alarm_valid_reg || alarm.ready;
    assign win_ready = !is_check || out_free;
    assign fire      = win_valid && win_ready;

    // Window bounds; the tolerance never exceeds the expected count.
    always_comb
    begin
        blood_hi = COUNT_W'(win.blood_expect) + COUNT_W'(win.blood_tol);
        blood_lo = COUNT_W'(win.blood_expect) - COUNT_W'(win.blood_tol);
        uf_hi    = win.uf_expect + UEXP_W'(win.uf_tol);
        uf_lo    = win.uf_expect - UEXP_W'(win.uf_tol);

        blood_above = win.blood_count > blood_hi;
        blood_below = win.blood_count < blood_lo;
        uf_above    = UEXP_W'(win.uf_count) > uf_hi;
        uf_below    = UEXP_W'(win.uf_count) < uf_lo;
    end

    // Countdown update: a countdown reloads while its condition is absent.
    always_comb
    begin
        if (is_check)
        begin
            blood_over_next  = blood_above ? blood_over_reg  : blood_persist_reg;
            blood_under_next = blood_below ? blood_under_reg : blood_persist_reg;
            uf_over_next     = uf_above    ? uf_over_reg     : uf_persist_reg;
            uf_under_next    = uf_below    ? uf_under_reg    : uf_persist_reg;
        end
        else
        begin
            blood_over_next  = dec_nonzero(blood_over_reg);
            blood_under_next = dec_nonzero(blood_under_reg);
            uf_over_next     = dec_nonzero(uf_over_reg);
            uf_under_next    = dec_nonzero(uf_under_reg);
        end

        blood_alarm_next = (blood_over_next == '0) || (blood_under_next == '0);
        uf_alarm_next    = (uf_over_next == '0) || (uf_under_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blood_over_reg  <= COUNTDOWN_RESET;
            blood_under_reg <= COUNTDOWN_RESET;
            uf_over_reg     <= COUNTDOWN_RESET;
            uf_under_reg    <= COUNTDOWN_RESET;
        end
        else if (fire)
        begin
            blood_over_reg  <= blood_over_next;
            blood_under_reg <= blood_under_next;
            uf_over_reg     <= uf_over_next;
            uf_under_reg    <= uf_under_next;
        end
    end

    // Reload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blood_persist_reg <= BLOOD_PERSIST_RESET;
            uf_persist_reg    <= UF_PERSIST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOOD_PERSIST: blood_persist_reg <= TICKS_W'(cfg_wdata);
                REG_UF_PERSIST:    uf_persist_reg    <= TICKS_W'(cfg_wdata);
                default:           ;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            alarm_valid_reg <= fire && is_check;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && fire && is_check)
        begin
            blood_alarm_reg <= blood_alarm_next;
            uf_alarm_reg    <= uf_alarm_next;
        end
    end

    assign alarm.valid       = alarm_valid_reg;
    assign alarm.blood_alarm = blood_alarm_reg;
    assign alarm.uf_alarm    = uf_alarm_reg;

endmodule

`default_nettype wire

// ===== sv/psw_checker.sv =====
// ============================================================================
// Pump speed window monitor checker
// Port-level checks on the result channel and backpressure.
// ============================================================================
`default_nettype none

module psw_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic item_ready,
    input wire logic alarm_valid,
    input wire logic alarm_ready,
    input wire logic blood_alarm,
    input wire logic uf_alarm
);

    // A stalled alarm word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        alarm_valid && !alarm_ready |=>
            alarm_valid && $stable(blood_alarm) && $stable(uf_alarm))
        else $error("alarm word changed while stalled");

    // Input backpressure comes only from a stalled alarm word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> alarm_valid && !alarm_ready)
        else $error("input stalled without a stalled alarm word");

    // The pipeline is empty straight after reset.
    assert property (@(posedge clk)
        !rst_n |=> !alarm_valid)
        else $error("alarm word present right after reset");

endmodule

bind pump_speed_window_monitor psw_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_ready  (item.ready),
    .alarm_valid (alarm.valid),
    .alarm_ready (alarm.ready),
    .blood_alarm (alarm.blood_alarm),
    .uf_alarm    (alarm.uf_alarm)
);

`default_nettype wire

// ===== verif/tb_pump_speed_window_monitor.sv =====
// ============================================================================
// Pump speed window monitor testbench
// Drives check and tick words through the item channel and compares every
// alarm word with a predictor of the four persistence countdowns or the
// wanted alarms of its row. A short table of directed words comes first,
// then phases of random pump behavior under different reload settings.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module tb_pump_speed_window_monitor;
    import psw_pkg::*;

    // Table rows are either a word to send or a pair of reload values.
    typedef enum logic {ROW_WORD, ROW_SETUP} row_kind_t;

    // How the random stimulus steers one pump's measured count.
    typedef enum logic [1:0] {SPEED_IN, SPEED_OVER, SPEED_UNDER, SPEED_NOISE} speed_mode_t;

    typedef struct packed {
        logic blood;
        logic uf;
    } alarm_pair_t;

    // A setup row carries the blood and uf reloads in the count fields.
    typedef struct {
        row_kind_t          kind;
        logic               action;
        logic [FLOW_W-1:0]  bflow;
        logic               hflow;
        logic [FLOW_W-1:0]  uflow;
        logic [COUNT_W-1:0] bcount;
        logic [COUNT_W-1:0] ucount;
        bit                 typed;
        logic               blood_want;
        logic               uf_want;
    } plan_row_t;

    localparam int PLAN_LEN     = 23;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 210;
    localparam int SETTLE_TICKS = 6;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    psw_item_if  item_if ();
    psw_alarm_if alarm_if ();

    pump_speed_window_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .alarm     (alarm_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: reload registers and the four countdowns.
    logic [TICKS_W-1:0] blood_reload;
    logic [TICKS_W-1:0] uf_reload;
    logic [TICKS_W-1:0] blood_over_cnt;
    logic [TICKS_W-1:0] blood_under_cnt;
    logic [TICKS_W-1:0] uf_over_cnt;
    logic [TICKS_W-1:0] uf_under_cnt;

    alarm_pair_t  alarm_q[$];
    plan_row_t    plan [PLAN_LEN];
    int unsigned  errors = 0;
    int unsigned  ready_hold = 0;
    bit           idle_free;

    // 20 ns clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Expected count and tolerance of one pump for a given setpoint.
    function automatic void size_window(input logic [FLOW_W-1:0] flow, input logic high_flow,
                                        input logic uf_side, output logic [16:0] centre,
                                        output logic [12:0] tol);
        logic [18:0] scaled;
        scaled = 19'(flow) * 19'd17;
        if (uf_side)
        begin
            centre = 17'(scaled >> 2);
            tol    = 13'(centre / 17'd10);
        end
        else
        begin
            centre = high_flow ? 17'(flow) : 17'(scaled / 19'd10);
            tol    = (centre > 17'd10) ? 13'(centre / 17'd10) : 13'(centre);
        end
    endfunction

    // Reload the countdowns of one pump from its count and report its alarm.
    function automatic logic judge_pump(input logic [COUNT_W-1:0] count,
                                        input logic [16:0] centre, input logic [12:0] tol,
                                        input logic [TICKS_W-1:0] reload,
                                        inout logic [TICKS_W-1:0] over_cnt,
                                        inout logic [TICKS_W-1:0] under_cnt);
        logic [17:0] upper;
        logic [17:0] lower;
        upper = 18'(centre) + 18'(tol);
        lower = 18'(centre) - 18'(tol);
        if (18'(count) > upper)
            under_cnt = reload;
        else if (18'(count) < lower)
            over_cnt = reload;
        else
        begin
            over_cnt  = reload;
            under_cnt = reload;
        end
        return (over_cnt == '0) || (under_cnt == '0);
    endfunction

    function automatic logic [TICKS_W-1:0] step_down(input logic [TICKS_W-1:0] v);
        return (v != '0) ? v - TICKS_W'(1) : '0;
    endfunction

    // Advance the predictor by one word; returns 1 when a check yields an alarm word.
    function automatic bit monitor_step(input psw_item_t w, output alarm_pair_t res);
        logic [16:0] centre;
        logic [12:0] tol;
        res = '0;
        if (w.action == ACT_TICK)
        begin
            blood_over_cnt  = step_down(blood_over_cnt);
            blood_under_cnt = step_down(blood_under_cnt);
            uf_over_cnt     = step_down(uf_over_cnt);
            uf_under_cnt    = step_down(uf_under_cnt);
            return 1'b0;
        end
        size_window(w.blood_flow_set, w.high_flow, 1'b0, centre, tol);
        res.blood = judge_pump(w.blood_count, centre, tol, blood_reload,
                               blood_over_cnt, blood_under_cnt);
        size_window(w.uf_flow_set, w.high_flow, 1'b1, centre, tol);
        res.uf = judge_pump(w.uf_count, centre, tol, uf_reload, uf_over_cnt, uf_under_cnt);
        return 1'b1;
    endfunction

    // Random setpoint: mostly in range, some tiny, some above 9999.
    function automatic logic [FLOW_W-1:0] draw_flow();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick < 2)
            return FLOW_W'($urandom_range(10000, 16383));
        else if (pick < 3)
            return FLOW_W'($urandom_range(0, 12));
        return FLOW_W'($urandom_range(0, 9999));
    endfunction

    // Measured count placed inside, above or below the window, or anywhere.
    function automatic logic [COUNT_W-1:0] aim_count(input speed_mode_t mode,
                                                     input logic [16:0] centre,
                                                     input logic [12:0] tol);
        logic [17:0] upper;
        logic [17:0] lower;
        logic [17:0] top;
        int unsigned pick;
        upper = 18'(centre) + 18'(tol);
        lower = 18'(centre) - 18'(tol);
        top   = (upper > 18'd65535) ? 18'd65535 : upper;
        pick  = $urandom_range(0, 3);
        case (mode)
            SPEED_IN:
            begin
                if (pick == 0)
                    return COUNT_W'(lower);
                if (pick == 1)
                    return COUNT_W'(top);
                return COUNT_W'($urandom_range(top, lower));
            end
            SPEED_OVER:
            begin
                if (upper >= 18'd65535)
                    return '1;
                if (pick < 2)
                    return COUNT_W'(upper + 18'd1);
                return COUNT_W'($urandom_range(65535, upper + 18'd1));
            end
            SPEED_UNDER:
            begin
                if (lower == '0)
                    return '0;
                if (pick < 2)
                    return COUNT_W'(lower - 18'd1);
                return COUNT_W'($urandom_range(lower - 18'd1, 0));
            end
            default:
                return COUNT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Send one word after a random gap and record what it should produce.
    task automatic send_word(input psw_item_t w, input bit typed, input alarm_pair_t typed_want);
        int unsigned gap;
        alarm_pair_t pred;
        gap = idle_free ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid          <= 1'b1;
        item_if.action         <= w.action;
        item_if.blood_flow_set <= w.blood_flow_set;
        item_if.high_flow      <= w.high_flow;
        item_if.uf_flow_set    <= w.uf_flow_set;
        item_if.blood_count    <= w.blood_count;
        item_if.uf_count       <= w.uf_count;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        if (monitor_step(w, pred))
            alarm_q.push_back(typed ? typed_want : pred);
    endtask

    // Stop sending and let every pending word, ticks included, leave the block.
    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (alarm_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write both reload registers on consecutive edges.
    task automatic write_persist(input logic [TICKS_W-1:0] blood_val,
                                 input logic [TICKS_W-1:0] uf_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BLOOD_PERSIST;
        cfg_wdata <= blood_val;
        @(posedge clk);
        blood_reload = blood_val;
        cfg_index <= REG_UF_PERSIST;
        cfg_wdata <= uf_val;
        @(posedge clk);
        uf_reload = uf_val;
        cfg_we <= 1'b0;
    endtask

    // Alarm word checker with random back-pressure.
    always @(posedge clk)
    begin : alarm_check
        alarm_pair_t want;
        if (rst_n && alarm_if.valid && alarm_if.ready)
        begin
            if (alarm_q.size() == 0)
            begin
                errors++;
                $display("%0t: alarm word with none expected: blood %0b uf %0b",
                         $time, alarm_if.blood_alarm, alarm_if.uf_alarm);
            end
            else
            begin
                want = alarm_q.pop_front();
                if (alarm_if.blood_alarm !== want.blood)
                begin
                    errors++;
                    $display("%0t: blood_alarm expected %0b, got %0b",
                             $time, want.blood, alarm_if.blood_alarm);
                end
                if (alarm_if.uf_alarm !== want.uf)
                begin
                    errors++;
                    $display("%0t: uf_alarm expected %0b, got %0b",
                             $time, want.uf, alarm_if.uf_alarm);
                end
            end
            ready_hold = idle_free ? 0 : $urandom_range(0, 3);
        end
        else if (ready_hold != 0)
        begin
            ready_hold--;
        end
        alarm_if.ready <= (ready_hold == 0);
    end

    // Main sequence: reset, directed table, random phases, verdict.
    initial
    begin
        psw_item_t   word;
        alarm_pair_t typed_want;
        speed_mode_t blood_mode;
        speed_mode_t uf_mode;
        logic [16:0] centre;
        logic [12:0] tol;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_BLOOD_PERSIST;
        cfg_wdata              = '0;
        item_if.valid          = 1'b0;
        item_if.action         = ACT_TICK;
        item_if.blood_flow_set = '0;
        item_if.high_flow      = 1'b0;
        item_if.uf_flow_set    = '0;
        item_if.blood_count    = '0;
        item_if.uf_count       = '0;
        idle_free              = 1'b0;
        blood_mode             = SPEED_IN;
        uf_mode                = SPEED_IN;

        blood_reload    = BLOOD_PERSIST_RESET;
        uf_reload       = UF_PERSIST_RESET;
        blood_over_cnt  = COUNTDOWN_RESET;
        blood_under_cnt = COUNTDOWN_RESET;
        uf_over_cnt     = COUNTDOWN_RESET;
        uf_under_cnt    = COUNTDOWN_RESET;

        plan = '{
            // Reset reloads and countdowns: no check can alarm yet.
            '{ROW_WORD, ACT_CHECK, 14'd0, 1'b1, 14'd0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'd0, 1'b0, 14'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'd9999, 1'b0, 14'd9999, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0},
            // Setpoints beyond 9999; the uf window then reaches past 16 bits.
            '{ROW_WORD, ACT_CHECK, 14'h3FFF, 1'b1, 14'h3FFF, 16'hFFFF, 16'hFFFF,
              1'b1, 1'b0, 1'b0},
            // Blood expected count of 10: the tolerance is the whole count.
            '{ROW_WORD, ACT_CHECK, 14'd10, 1'b1, 14'd1, 16'd20, 16'd4, 1'b1, 1'b0, 1'b0},
            '{ROW_WORD, ACT_TICK, 14'h3FFF, 1'b1, 14'h3FFF, 16'hFFFF, 16'hFFFF,
              1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'd11, 1'b1, 14'd2, 16'd13, 16'd9, 1'b1, 1'b0, 1'b0},
            // Zero reloads: every check alarms at once.
            '{ROW_SETUP, ACT_TICK, 14'd0, 1'b0, 14'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'd1000, 1'b0, 14'd1000, 16'd1700, 16'd4250,
              1'b1, 1'b1, 1'b1},
            // Tick with the countdowns already at zero.
            '{ROW_WORD, ACT_TICK, 14'd0, 1'b0, 14'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'd0, 1'b1, 14'd0, 16'd5, 16'd5, 1'b1, 1'b1, 1'b1},
            // Short reloads: countdowns left at zero keep it until reloaded.
            '{ROW_SETUP, ACT_TICK, 14'd0, 1'b0, 14'd0, 16'd2, 16'd3, 1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'd1000, 1'b0, 14'd1000, 16'd2000, 16'd100,
              1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_TICK, 14'd0, 1'b0, 14'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_TICK, 14'd0, 1'b0, 14'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'd1000, 1'b0, 14'd1000, 16'd2000, 16'd100,
              1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_TICK, 14'd0, 1'b0, 14'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'd1000, 1'b0, 14'd1000, 16'd2000, 16'd100,
              1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'd1000, 1'b0, 14'd1000, 16'd1700, 16'd4250,
              1'b0, 1'b0, 1'b0},
            // Largest reloads.
            '{ROW_SETUP, ACT_TICK, 14'd0, 1'b0, 14'd0, 16'hFFFF, 16'hFFFF,
              1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'h3FFF, 1'b0, 14'd12345, 16'd27851, 16'd52466,
              1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_TICK, 14'd0, 1'b0, 14'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_WORD, ACT_CHECK, 14'd500, 1'b1, 14'd500, 16'd451, 16'd2125,
              1'b0, 1'b0, 1'b0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SETUP)
            begin
                drain_results();
                write_persist(plan[i].bcount, plan[i].ucount);
            end
            else
            begin
                word.action         = plan[i].action;
                word.blood_flow_set = plan[i].bflow;
                word.high_flow      = plan[i].hflow;
                word.uf_flow_set    = plan[i].uflow;
                word.blood_count    = plan[i].bcount;
                word.uf_count       = plan[i].ucount;
                typed_want.blood    = plan[i].blood_want;
                typed_want.uf       = plan[i].uf_want;
                send_word(word, plan[i].typed, typed_want);
            end
        end

        // Random phases, each under its own reload setting.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0: write_persist(16'd1, 16'hFFFF);
                1: write_persist(16'hFFFF, 16'd1);
                5: write_persist(TICKS_W'($urandom_range(0, 2)),
                                 TICKS_W'($urandom_range(0, 2)));
                default: write_persist(TICKS_W'($urandom_range(1, 8)),
                                       TICKS_W'($urandom_range(1, 8)));
            endcase
            idle_free = (phase % 3 == 2);
            typed_want = '0;
            repeat (PHASE_WORDS)
            begin
                // Each pump holds a speed behavior for a stretch of words.
                if ($urandom_range(0, 15) == 0)
                    blood_mode = speed_mode_t'($urandom_range(0, 3));
                if ($urandom_range(0, 15) == 0)
                    uf_mode = speed_mode_t'($urandom_range(0, 3));
                word.action         = ($urandom_range(0, 9) < 4) ? ACT_TICK : ACT_CHECK;
                word.blood_flow_set = draw_flow();
                word.high_flow      = 1'($urandom_range(0, 1));
                word.uf_flow_set    = draw_flow();
                size_window(word.blood_flow_set, word.high_flow, 1'b0, centre, tol);
                word.blood_count = aim_count(blood_mode, centre, tol);
                size_window(word.uf_flow_set, word.high_flow, 1'b1, centre, tol);
                word.uf_count = aim_count(uf_mode, centre, tol);
                send_word(word, 1'b0, typed_want);
            end
        end

        idle_free = 1'b0;
        drain_results();
        if (errors == 0)
            $display("tb_pump_speed_window_monitor: PASS");
        else
            $display("tb_pump_speed_window_monitor: FAIL");
        $finish;
    end

    // Watchdog well beyond the slowest passing run.
    initial
    begin
        #5_000_000;
        $display("tb_pump_speed_window_monitor: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
